FILE: hw/rtl/stq_pkg.sv
package stq_pkg;

  // Field widths
  localparam int unsigned SecsW = 16;
  localparam int unsigned PidW  = 8;
  localparam int unsigned OccW  = 4;
  localparam int unsigned StatW = 2;

  // Default pool size
  localparam int unsigned DefaultPoolDepth = 8;

  // Command codes carried on the input tuser
  localparam logic CmdInsert = 1'b0;
  localparam logic CmdPop    = 1'b1;

  // Result status codes
  localparam logic [StatW-1:0] StatOk    = 2'd0;
  localparam logic [StatW-1:0] StatFull  = 2'd1;
  localparam logic [StatW-1:0] StatEmpty = 2'd2;

  // Operation broadcast from the top level to every cell
  typedef struct packed {
    logic             ins;
    logic             pop;
    logic [SecsW-1:0] secs;
    logic [PidW-1:0]  pid;
  } stq_ctrl_t;

endpackage

FILE: hw/rtl/stq_cell.sv
module stq_cell (
  input  logic                      clk_i,
  input  stq_pkg::stq_ctrl_t        ctrl_i,
  input  logic                      occ_i,
  input  logic                      prev_le_i,
  input  logic [stq_pkg::SecsW-1:0] prev_secs_i,
  input  logic [stq_pkg::PidW-1:0]  prev_pid_i,
  input  logic [stq_pkg::SecsW-1:0] next_secs_i,
  input  logic [stq_pkg::PidW-1:0]  next_pid_i,
  output logic                      le_o,
  output logic [stq_pkg::SecsW-1:0] secs_o,
  output logic [stq_pkg::PidW-1:0]  pid_o
);

  logic [stq_pkg::SecsW-1:0] secs_q, secs_d;
  logic [stq_pkg::PidW-1:0]  pid_q, pid_d;

  // Entry stays ahead of the new key when it is queued and not later
  assign le_o = occ_i && (secs_q <= ctrl_i.secs);

  // Keep, take the new entry, shift from the left on insert, or from the right on pop
  always_comb begin
    secs_d = secs_q;
    pid_d  = pid_q;
    if (ctrl_i.ins) begin
      if (le_o) begin
        secs_d = secs_q;
        pid_d  = pid_q;
      end else if (prev_le_i) begin
        secs_d = ctrl_i.secs;
        pid_d  = ctrl_i.pid;
      end else begin
        secs_d = prev_secs_i;
        pid_d  = prev_pid_i;
      end
    end else if (ctrl_i.pop) begin
      secs_d = next_secs_i;
      pid_d  = next_pid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    secs_q <= secs_d;
    pid_q  <= pid_d;
  end

  assign secs_o = secs_q;
  assign pid_o  = pid_q;

endmodule

FILE: hw/rtl/sorted_timer_queue.sv
// A result appears on the master side in the cycle after its input transfer.
// Throughput: one insert or pop per cycle; every cell compares and shifts in that same cycle.
// A result waiting on the master side does not block input when it is taken that cycle.
// Reset: rst_ni is asynchronous, active low; it empties the queue and drops the pending result.
// Entry storage is not reset; only queued slots are ever read.
module sorted_timer_queue #(
  parameter int unsigned POOL_DEPTH = stq_pkg::DefaultPoolDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [15:0] wait_seconds, [23:16] proc_id
  input  logic        s_axis_tuser,   // [0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] out_seconds, [23:16] out_proc_id,
                                      // [27:24] occupancy, [31:28] zero
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  localparam int unsigned CntW = $clog2(POOL_DEPTH + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            in_xfer;
  logic            is_pop;
  logic            full;
  logic            empty;
  logic            ins_ok;
  logic            pop_ok;

  stq_pkg::stq_ctrl_t ctrl;

  logic [POOL_DEPTH-1:0]   occ;
  logic [POOL_DEPTH:0]     le_chain;
  logic [stq_pkg::SecsW-1:0] secs_chain [POOL_DEPTH+1:0];
  logic [stq_pkg::PidW-1:0]  pid_chain  [POOL_DEPTH+1:0];

  logic                      out_valid_q;
  logic [stq_pkg::StatW-1:0] out_stat_q, out_stat_d;
  logic [stq_pkg::SecsW-1:0] out_secs_q, out_secs_d;
  logic [stq_pkg::PidW-1:0]  out_pid_q, out_pid_d;
  logic [stq_pkg::OccW-1:0]  out_occ_q;

  // Accept while the output register is empty or being drained
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Decode the command and reject insert-when-full and pop-when-empty
  assign is_pop = (s_axis_tuser == stq_pkg::CmdPop);
  assign full   = (cnt_q == CntW'(POOL_DEPTH));
  assign empty  = (cnt_q == '0);
  assign ins_ok = in_xfer && !is_pop && !full;
  assign pop_ok = in_xfer && is_pop && !empty;

  assign ctrl.ins  = ins_ok;
  assign ctrl.pop  = pop_ok;
  assign ctrl.secs = s_axis_tdata[15:0];
  assign ctrl.pid  = s_axis_tdata[23:16];

  // Boundary taps of the chain
  assign le_chain[0]               = 1'b1;
  assign secs_chain[0]             = '0;
  assign pid_chain[0]              = '0;
  assign secs_chain[POOL_DEPTH+1]  = '0;
  assign pid_chain[POOL_DEPTH+1]   = '0;

  // Row of cells, slot 0 holds the head
  for (genvar k = 0; k < POOL_DEPTH; k++) begin : g_cell
    assign occ[k] = (cnt_q > CntW'(k));

    stq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occ_i       (occ[k]),
      .prev_le_i   (le_chain[k]),
      .prev_secs_i (secs_chain[k]),
      .prev_pid_i  (pid_chain[k]),
      .next_secs_i (secs_chain[k+2]),
      .next_pid_i  (pid_chain[k+2]),
      .le_o        (le_chain[k+1]),
      .secs_o      (secs_chain[k+1]),
      .pid_o       (pid_chain[k+1])
    );
  end

  // Advance the entry count
  always_comb begin
    cnt_d = cnt_q;
    if (ins_ok) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_ok) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  // Build the result
  always_comb begin
    out_stat_d = stq_pkg::StatOk;
    out_secs_d = '0;
    out_pid_d  = '0;
    if (is_pop) begin
      if (empty) begin
        out_stat_d = stq_pkg::StatEmpty;
      end else begin
        out_secs_d = secs_chain[1];
        out_pid_d  = pid_chain[1];
      end
    end else if (full) begin
      out_stat_d = stq_pkg::StatFull;
    end
  end

  // Hold count and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (in_xfer) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the result payload on each input transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_stat_q <= out_stat_d;
      out_secs_q <= out_secs_d;
      out_pid_q  <= out_pid_d;
      out_occ_q  <= stq_pkg::OccW'(cnt_d);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_stat_q;
  assign m_axis_tdata  = {4'b0000, out_occ_q, out_pid_q, out_secs_q};

  // Count never exceeds the pool
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(POOL_DEPTH))
    else $error("entry count above pool depth");

  // A successful pop removes exactly one entry
  a_pop_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_ok |=> cnt_q == $past(cnt_q) - CntW'(1))
    else $error("pop did not decrement count");

  // A rejected pop reports zero data
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stat_q == stq_pkg::StatEmpty) |-> (out_secs_q == '0 && out_pid_q == '0))
    else $error("empty pop returned data");

  // Queued entries stay sorted by wait time
  for (genvar k = 0; k + 1 < POOL_DEPTH; k++) begin : g_chk
    a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
      occ[k+1] |-> secs_chain[k+1] <= secs_chain[k+2])
      else $error("queue out of order");
  end

endmodule

FILE: tb/sv/sorted_timer_queue_test.sv
module sorted_timer_queue_test;

  localparam int unsigned PoolDepth   = stq_pkg::DefaultPoolDepth;
  localparam int unsigned RandomItems = 1700;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned CycleLimit  = 400000;

  // One reply of the queue, as it should appear on the master side
  typedef struct packed {
    logic [stq_pkg::StatW-1:0] status;
    logic [stq_pkg::SecsW-1:0] secs;
    logic [stq_pkg::PidW-1:0]  pid;
    logic [stq_pkg::OccW-1:0]  occupancy;
  } timer_reply_t;

  typedef enum int unsigned {RxAlways, RxMostly, RxSparse, RxToggle} rx_style_e;

  // Tracks the sorted pool and checks every reply in order
  class timer_order_checker;
    logic [stq_pkg::SecsW-1:0] slot_secs [PoolDepth];
    logic [stq_pkg::PidW-1:0]  slot_pid  [PoolDepth];
    int unsigned               queued;
    timer_reply_t              awaited_replies [$];
    int unsigned               errors;

    function new();
      queued = 0;
      errors = 0;
    endfunction

    // Apply one accepted command to the pool and queue its reply
    function void note_request(logic cmd, logic [stq_pkg::SecsW-1:0] secs,
                               logic [stq_pkg::PidW-1:0] pid);
      timer_reply_t rep;
      int unsigned  pos;
      int unsigned  k;
      rep = '0;
      if (cmd == stq_pkg::CmdInsert) begin
        if (queued >= PoolDepth) begin
          rep.status = stq_pkg::StatFull;
        end else begin
          // place after every entry whose time is not greater
          pos = 0;
          while (pos < queued && slot_secs[pos] <= secs) pos++;
          for (k = queued; k > pos; k--) begin
            slot_secs[k] = slot_secs[k-1];
            slot_pid[k]  = slot_pid[k-1];
          end
          slot_secs[pos] = secs;
          slot_pid[pos]  = pid;
          queued++;
          rep.status = stq_pkg::StatOk;
        end
      end else begin
        if (queued == 0) begin
          rep.status = stq_pkg::StatEmpty;
        end else begin
          rep.status = stq_pkg::StatOk;
          rep.secs   = slot_secs[0];
          rep.pid    = slot_pid[0];
          for (k = 1; k < queued; k++) begin
            slot_secs[k-1] = slot_secs[k];
            slot_pid[k-1]  = slot_pid[k];
          end
          queued--;
        end
      end
      rep.occupancy = queued[stq_pkg::OccW-1:0];
      awaited_replies.push_back(rep);
    endfunction

    function void compare_field(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
        $error("%s: expected %0d, got %0d", name, exp, act);
        errors++;
      end
    endfunction

    // Compare one accepted reply with the oldest awaited one
    function void check_reply(logic [31:0] data, logic [stq_pkg::StatW-1:0] user);
      timer_reply_t rep;
      if (awaited_replies.size() == 0) begin
        $error("reply with none awaited: tdata %h, tuser %h", data, user);
        errors++;
        return;
      end
      rep = awaited_replies.pop_front();
      compare_field("status", rep.status, user);
      compare_field("out_seconds", rep.secs, data[15:0]);
      compare_field("out_proc_id", rep.pid, data[23:16]);
      compare_field("occupancy", rep.occupancy, data[27:24]);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // [15:0] wait_seconds, [23:16] proc_id
  logic        s_axis_tuser = 1'b0; // [0] cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [15:0] out_seconds, [23:16] out_proc_id, [27:24] occupancy
  logic [1:0]  m_axis_tuser;        // [1:0] status

  timer_order_checker order_chk = new();
  int unsigned        hold_requests = 0;
  int unsigned        cycle_count = 0;

  sorted_timer_queue #(
    .POOL_DEPTH(PoolDepth)
  ) u_top (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watch both sides; note requests before checking replies
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        order_chk.note_request(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[23:16]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        order_chk.check_reply(m_axis_tdata, m_axis_tuser);
      end
    end
  end

  // Offer one command and hold it until the transfer
  task automatic send_cmd(logic cmd, logic [stq_pkg::SecsW-1:0] secs,
                          logic [stq_pkg::PidW-1:0] pid);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pid, secs};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Drop valid and put noise on the data lines for a while
  task automatic idle_for(int unsigned cycles);
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 24'($urandom);
    s_axis_tuser  <= 1'($urandom);
    repeat (cycles) @(posedge clk_i);
  endtask

  // Favor small and extreme wait times so equal keys show up often
  function automatic logic [stq_pkg::SecsW-1:0] pick_wait();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return stq_pkg::SecsW'($urandom_range(0, 7));
    if (sel == 4) return ($urandom_range(0, 1) != 0) ? '1 : '0;
    return stq_pkg::SecsW'($urandom);
  endfunction

  // Receiver stall pattern, with long hold-offs on request
  initial begin : rx_pattern
    rx_style_e   style;
    int unsigned style_left;
    int unsigned hold_left;
    int unsigned holds_served;
    style        = RxAlways;
    style_left   = 0;
    hold_left    = 0;
    holds_served = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && holds_served < hold_requests) begin
        hold_left = LongHold;
        holds_served++;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (style_left == 0) begin
          style      = rx_style_e'($urandom_range(0, 3));
          style_left = $urandom_range(20, 200);
        end
        style_left--;
        case (style)
          RxAlways: m_axis_tready <= 1'b1;
          RxMostly: m_axis_tready <= ($urandom_range(0, 3) != 0);
          RxSparse: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default:  m_axis_tready <= style_left[0];
        endcase
      end
    end
  end

  // End the run if it never drains
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Stimulus
  initial begin
    int unsigned sent;
    int unsigned burst;
    int unsigned ins_pct;
    int unsigned bias_left;
    logic        cmd;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Pop from an empty queue
    send_cmd(stq_pkg::CmdPop, '1, '1);
    // Fill the pool with extremes and equal times
    send_cmd(stq_pkg::CmdInsert, 16'd100, 8'd1);
    send_cmd(stq_pkg::CmdInsert, 16'd0, 8'd0);
    send_cmd(stq_pkg::CmdInsert, 16'hFFFF, 8'hFF);
    send_cmd(stq_pkg::CmdInsert, 16'd100, 8'd2);
    send_cmd(stq_pkg::CmdInsert, 16'd50, 8'd3);
    send_cmd(stq_pkg::CmdInsert, 16'd100, 8'd4);
    send_cmd(stq_pkg::CmdInsert, 16'hFFFF, 8'd5);
    send_cmd(stq_pkg::CmdInsert, 16'd0, 8'd6);
    // Insert into a full pool
    send_cmd(stq_pkg::CmdInsert, 16'd7, 8'd200);
    // Drain in order, then pop empty again
    repeat (PoolDepth) send_cmd(stq_pkg::CmdPop, '0, '0);
    send_cmd(stq_pkg::CmdPop, 16'h5A5A, 8'hA5);
    // Insert and pop straddling the empty state
    send_cmd(stq_pkg::CmdInsert, 16'hFFFF, 8'h80);
    send_cmd(stq_pkg::CmdPop, '0, '0);

    // Random traffic, biased in phases so the pool swings between full and empty
    hold_requests = 1;
    sent      = 0;
    ins_pct   = 50;
    bias_left = 0;
    while (sent < RandomItems) begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 20);
      while (burst != 0 && sent < RandomItems) begin
        if (bias_left == 0) begin
          case ($urandom_range(0, 2))
            0:       ins_pct = 15;
            1:       ins_pct = 50;
            default: ins_pct = 85;
          endcase
          bias_left = $urandom_range(10, 60);
        end
        bias_left--;
        cmd = ($urandom_range(0, 99) < ins_pct) ? stq_pkg::CmdInsert : stq_pkg::CmdPop;
        send_cmd(cmd, pick_wait(), stq_pkg::PidW'($urandom));
        sent++;
        burst--;
        if (sent == RandomItems / 2) hold_requests = 2;
      end
      if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 8));
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (order_chk.awaited_replies.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (order_chk.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
